@@ rtl/shbi_pkg.sv @@
`timescale 1ns / 1ps

package shbi_pkg;

    // Field and register widths
    localparam int HASH_W   = 32;
    localparam int KEY_W    = 8;
    localparam int BCNT_W   = 21;
    localparam int IDX_W    = 20;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    // Remainder divider: one dividend bit per step
    localparam int DIV_STEPS = HASH_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [BCNT_W-1:0] MAX_BUCKETS  = BCNT_W'(1048576);
    localparam logic [BCNT_W-1:0] BUCKET_RESET = BCNT_W'(16);

    // Register index decoded from paddr[2]
    localparam logic REG_BUCKET_COUNT = 1'b0;

    // Controller to datapath commands
    typedef struct packed {
        logic absorb;
        logic finalize;
        logic div_step;
        logic load_out;
    } shbi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
    } shbi_sts_t;

endpackage

@@ rtl/shbi_if.sv @@
`timescale 1ns / 1ps

interface shbi_key_if;
    import shbi_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_byte;
    logic              byte_valid;
    logic              last_byte;

    modport source (output valid, key_byte, byte_valid, last_byte, input ready);
    modport sink   (input valid, key_byte, byte_valid, last_byte, output ready);
endinterface

interface shbi_res_if;
    import shbi_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;
    logic [IDX_W-1:0]  bucket_index;

    modport source (output valid, hash_value, bucket_index, input ready);
    modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

@@ rtl/shbi_ctrl.sv @@
`timescale 1ns / 1ps

module shbi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  shbi_pkg::shbi_sts_t sts,
    output shbi_pkg::shbi_cmd_t cmd
);
    import shbi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Decode commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd.absorb   = 1'b0;
        cmd.finalize = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.absorb = in_fire;
                if (in_fire && in_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finalize = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set on result load, drop when the request is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/shbi_dp.sv @@
`timescale 1ns / 1ps

module shbi_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shbi_pkg::shbi_cmd_t           cmd,
    output shbi_pkg::shbi_sts_t           sts,
    input  logic [shbi_pkg::KEY_W-1:0]    key_byte,
    input  logic                          byte_valid,
    input  logic [shbi_pkg::BCNT_W-1:0]   bucket_count,
    output logic [shbi_pkg::HASH_W-1:0]   hash_value,
    output logic [shbi_pkg::IDX_W-1:0]    bucket_index
);
    import shbi_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] fin_reg;
    logic [HASH_W-1:0] dvd_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [HASH_W-1:0] hash_out_reg;
    logic [IDX_W-1:0]  index_out_reg;

    logic [HASH_W-1:0] ext;
    logic [HASH_W-1:0] a1;
    logic [HASH_W-1:0] a2;
    logic [HASH_W-1:0] a3;
    logic [HASH_W-1:0] f1;
    logic [HASH_W-1:0] f2;
    logic [HASH_W-1:0] f3;
    logic [HASH_W-1:0] mag;
    logic [BCNT_W-1:0] modulus;
    logic [BCNT_W-1:0] trial;
    logic [BCNT_W-1:0] diff;

    // Absorb one sign-extended byte
    always_comb
    begin
        ext = {{(HASH_W-KEY_W){key_byte[KEY_W-1]}}, key_byte};
        a1  = hash_reg + ext;
        a2  = a1 + (a1 << 10);
        a3  = a2 ^ (a2 >> 6);
    end

    // Finalize and take the two's-complement magnitude
    always_comb
    begin
        f1  = hash_reg + (hash_reg << 3);
        f2  = f1 ^ (f1 >> 11);
        f3  = f2 + (f2 << 15);
        mag = f3[HASH_W-1] ? (~f3 + HASH_W'(1)) : f3;
    end

    // Clamp the bucket count into the legal modulus range
    always_comb
    begin
        if (bucket_count == '0)
        begin
            modulus = BCNT_W'(1);
        end
        else if (bucket_count > MAX_BUCKETS)
        begin
            modulus = MAX_BUCKETS;
        end
        else
        begin
            modulus = bucket_count;
        end
    end

    // One restoring remainder step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[HASH_W-1]};
        diff  = trial - modulus;
    end

    assign sts.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Running hash: clear on finalize
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else if (cmd.finalize)
        begin
            hash_reg <= '0;
        end
        else if (cmd.absorb && byte_valid)
        begin
            hash_reg <= a3;
        end
    end

    // Divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finalize)
        begin
            fin_reg <= f3;
            dvd_reg <= mag;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (trial >= modulus)
            begin
                rem_reg <= diff[IDX_W-1:0];
            end
            else
            begin
                rem_reg <= trial[IDX_W-1:0];
            end
        end
        if (cmd.load_out)
        begin
            hash_out_reg  <= fin_reg;
            index_out_reg <= rem_reg;
        end
    end

    assign hash_value   = hash_out_reg;
    assign bucket_index = index_out_reg;

endmodule

@@ rtl/string_hash_bucket_index.sv @@
`timescale 1ns / 1ps
// Channel     Dir  Fields                                   Handshake
// key_in      in   key_byte[7:0], byte_valid, last_byte     valid/ready
// result_out  out  hash_value[31:0], bucket_index[19:0]     valid/ready
// apb         in   bucket_count at byte address 0           psel/penable/pready
//
// Items without last_byte leave key_in ready. An item with last_byte is absorbed,
// then the next is taken only after finalize, 32 remainder steps of the
// bit-serial divider, and the load into the output register.
// Reset clears the running hash and control state and sets bucket_count to 16.
// A stalled result waits in the output register; key bytes are taken meanwhile
// until the next key end needs that register.

module string_hash_bucket_index (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shbi_pkg::ADDR_W-1:0]   paddr,
    input  logic [shbi_pkg::APB_W-1:0]    pwdata,
    output logic [shbi_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    shbi_key_if.sink                      key_in,
    shbi_res_if.source                    result_out
);
    import shbi_pkg::*;

    logic [BCNT_W-1:0] bucket_count_reg;
    logic              reg_sel;
    shbi_cmd_t         cmd;
    shbi_sts_t         sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_BUCKET_COUNT);

    // Write the bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            bucket_count_reg <= pwdata[BCNT_W-1:0];
        end
    end

    // Read back the register, zero beyond the list
    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = {{(APB_W-BCNT_W){1'b0}}, bucket_count_reg};
        end
    end

    shbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (key_in.valid),
        .in_last   (key_in.last_byte),
        .in_ready  (key_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    shbi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .key_byte     (key_in.key_byte),
        .byte_valid   (key_in.byte_valid),
        .bucket_count (bucket_count_reg),
        .hash_value   (result_out.hash_value),
        .bucket_index (result_out.bucket_index)
    );

endmodule
